FILE: rtl/sat_pkg.sv
// Shared types and constants for the sweep auto-range tracker.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int unsigned DATA_W  = 17;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] MIN_SPAN_RESET   = 17'd1000;
    localparam logic [DATA_W-1:0] FULL_SCALE_RESET = 17'd131071;
    localparam logic [DATA_W-1:0] SHOWN_HIGH_RESET = 17'd131071;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2**18
    localparam logic [17:0] DIV10_MUL   = 18'd209716;
    localparam int unsigned DIV10_SHIFT = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_SPAN   = 2'd0,
        REG_FULL_SCALE = 2'd1
    } sat_reg_idx_t;

    // Tracker stage result: tick info plus the extremes after this sample
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               present;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  ext_low;
        logic [DATA_W-1:0]  ext_high;
        logic [DATA_W-1:0]  span;
        logic [DATA_W-1:0]  mid;
        logic               ended;
    } sat_trk_t;

    // Widened bounds before clamping; low is two's complement, high may overflow
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               present;
        logic [DATA_W-1:0]  value;
        logic [DATA_W+1:0]  raw_low;
        logic [DATA_W:0]    raw_high;
        logic               ended;
    } sat_raw_t;

    // Finished result transaction
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               present;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  range_low;
        logic [DATA_W-1:0]  range_high;
        logic               changed;
        logic               ended;
    } sat_res_t;

endpackage

FILE: rtl/sweep_autorange_tracker.sv
// Top level of the sweep auto-range tracker: ports, configuration, pipeline.
`timescale 1ns / 1ps

// Channel   | Handshake                      | Payload
// ----------+--------------------------------+---------------------------------------
// input     | s_axis_tvalid / s_axis_tready  | tdata: sample; tuser: has_sample
// result    | m_axis_tvalid / m_axis_tready  | tdata: index, value, low, high, changed;
//           |                                | tuser: point_present; tlast: sweep_end
// config    | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One tick is accepted per cycle while the result side takes results; a result passes
// the registered stages in order (tracker, range widening, clamp/result register)
// before it is presented. The rate is set by the extreme update in the tracker stage.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes the sweep, and
// restores the shown range to 0..131071 and the registers to their defaults.
// A stall on the result side holds every stage in place; input is taken as long
// as any stage ahead has room. Configuration is to be written only while idle;
// the block itself does not enforce this.

module sweep_autorange_tracker #(
    parameter int unsigned SWEEP_POINTS = 250
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // [16:0] sample
    input  logic                          s_axis_tuser,   // [0] has_sample

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] point_index, [24:8] point_value, [41:25] range_low,
    // [58:42] range_high, [59] range_changed, [63:60] zero
    output logic [63:0]                   m_axis_tdata,
    output logic                          m_axis_tuser,   // [0] point_present
    output logic                          m_axis_tlast,   // sweep_end

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sat_pkg::DATA_W-1:0]    cfg_data
);
    import sat_pkg::*;

    logic [DATA_W-1:0] min_span_reg, min_span_next;
    logic [DATA_W-1:0] full_scale_reg, full_scale_next;

    sat_trk_t trk_data;
    sat_raw_t raw_data;
    sat_res_t res_data;
    logic     trk_valid, trk_ready;
    logic     raw_valid, raw_ready;

    // Configuration: always ready outside reset; unknown indexes are dropped
    assign cfg_ready = aresetn;

    always_comb begin
        min_span_next   = min_span_reg;
        full_scale_next = full_scale_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_SPAN:   min_span_next   = cfg_data;
                REG_FULL_SCALE: full_scale_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_span_reg   <= MIN_SPAN_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
        end else begin
            min_span_reg   <= min_span_next;
            full_scale_reg <= full_scale_next;
        end
    end

    // Stage 1: advance the sweep position and update the extremes
    sat_track #(
        .SWEEP_POINTS (SWEEP_POINTS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .has_sample (s_axis_tuser),
        .sample     (s_axis_tdata[DATA_W-1:0]),
        .out_valid  (trk_valid),
        .out_ready  (trk_ready),
        .out_data   (trk_data)
    );

    // Stage 2: widen about the midpoint or by a tenth of the span
    sat_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .min_span  (min_span_reg),
        .in_valid  (trk_valid),
        .in_ready  (trk_ready),
        .in_data   (trk_data),
        .out_valid (raw_valid),
        .out_ready (raw_ready),
        .out_data  (raw_data)
    );

    // Stage 3: clamp to full scale, compare with the shown range, hold result
    sat_range u_range (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .full_scale (full_scale_reg),
        .in_valid   (raw_valid),
        .in_ready   (raw_ready),
        .in_data    (raw_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (res_data)
    );

    assign m_axis_tdata = {4'b0000, res_data.changed, res_data.range_high,
                           res_data.range_low, res_data.value, res_data.index};
    assign m_axis_tuser = res_data.present;
    assign m_axis_tlast = res_data.ended;

`ifndef ASSERT_OFF
    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res_data.range_low <= res_data.range_high))
        else $error("range low above range high");
    a_gap_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (res_data.value == '0 && !res_data.changed))
        else $error("gap tick carries a value or a range change");
    a_last_at_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (res_data.index == INDEX_W'(SWEEP_POINTS - 1))))
        else $error("sweep end does not match the final position");
    a_within_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && res_data.changed) |-> (res_data.range_high <= full_scale_reg))
        else $error("new range exceeds full scale");
`endif

endmodule

FILE: rtl/sat_track.sv
// Sweep position and running extremes of the current sweep.
`timescale 1ns / 1ps

module sat_track #(
    parameter int unsigned SWEEP_POINTS = 250
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     has_sample,
    input  logic [sat_pkg::DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sat_pkg::sat_trk_t        out_data
);
    import sat_pkg::*;

    localparam int unsigned POS_W = $clog2(SWEEP_POINTS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SWEEP_POINTS - 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              seen_reg, seen_next;
    logic [DATA_W-1:0] min_reg, min_next;
    logic [DATA_W-1:0] max_reg, max_next;
    logic              valid_reg;
    sat_trk_t          data_reg, data_next;

    logic              accept;
    logic              last_pos;
    logic [DATA_W-1:0] new_min, new_max;
    logic [DATA_W:0]   ext_sum;

    assign in_ready  = (!valid_reg || out_ready) && aresetn;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign last_pos  = (pos_reg == POS_LAST);

    always_comb begin
        new_min = (!seen_reg || sample < min_reg) ? sample : min_reg;
        new_max = (!seen_reg || sample > max_reg) ? sample : max_reg;
        ext_sum = {1'b0, new_max} + {1'b0, new_min};

        data_next.index    = INDEX_W'(pos_reg);
        data_next.present  = has_sample;
        data_next.value    = has_sample ? sample : '0;
        data_next.ext_low  = new_min;
        data_next.ext_high = new_max;
        data_next.span     = new_max - new_min;
        data_next.mid      = ext_sum[DATA_W:1];
        data_next.ended    = last_pos;

        pos_next  = pos_reg;
        seen_next = seen_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        if (accept) begin
            if (last_pos) begin
                pos_next  = '0;
                seen_next = 1'b0;
                min_next  = '0;
                max_next  = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (has_sample) begin
                    seen_next = 1'b1;
                    min_next  = new_min;
                    max_next  = new_max;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            min_reg   <= '0;
            max_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

`ifndef ASSERT_OFF
    a_wrap_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_pos) |=> (pos_reg == '0 && !seen_reg && min_reg == '0 && max_reg == '0))
        else $error("sweep wrap did not clear the tracker");
    a_extremes_order: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (min_reg <= max_reg))
        else $error("sweep minimum above maximum");
`endif

endmodule

FILE: rtl/sat_scale.sv
// Widen the extremes into an unclamped display range.
`timescale 1ns / 1ps

module sat_scale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [sat_pkg::DATA_W-1:0] min_span,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sat_pkg::sat_trk_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sat_pkg::sat_raw_t          out_data
);
    import sat_pkg::*;

    logic              valid_reg;
    sat_raw_t          data_reg, data_next;

    logic              narrow;
    logic [DATA_W-2:0] half;
    logic [DATA_W+17:0] prod;
    logic [DATA_W-1:0] margin;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        narrow = (in_data.span < min_span);
        half   = min_span[DATA_W-1:1];
        prod   = {18'd0, in_data.span} * {17'd0, DIV10_MUL};
        margin = DATA_W'(prod >> DIV10_SHIFT);

        data_next.index   = in_data.index;
        data_next.present = in_data.present;
        data_next.value   = in_data.value;
        data_next.ended   = in_data.ended;
        if (narrow) begin
            data_next.raw_high = {1'b0, in_data.mid} + {2'b00, half};
            data_next.raw_low  = {2'b00, in_data.mid} - {3'b000, half};
        end else begin
            data_next.raw_high = {1'b0, in_data.ext_high} + {1'b0, margin};
            data_next.raw_low  = {2'b00, in_data.ext_low} - {2'b00, margin};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/sat_range.sv
// Clamp the range, track the shown bounds and hold the result register.
`timescale 1ns / 1ps

module sat_range (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [sat_pkg::DATA_W-1:0] full_scale,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sat_pkg::sat_raw_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sat_pkg::sat_res_t          out_data
);
    import sat_pkg::*;

    logic              valid_reg;
    sat_res_t          data_reg, data_next;
    logic [DATA_W-1:0] shown_low_reg, shown_low_next;
    logic [DATA_W-1:0] shown_high_reg, shown_high_next;

    logic              accept;
    logic [DATA_W-1:0] lo_c, hi_c;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        // negative low clamps to zero, anything above full scale to full scale
        if (in_data.raw_low[DATA_W+1]) begin
            lo_c = '0;
        end else if (in_data.raw_low[DATA_W:0] > {1'b0, full_scale}) begin
            lo_c = full_scale;
        end else begin
            lo_c = in_data.raw_low[DATA_W-1:0];
        end
        if (in_data.raw_high > {1'b0, full_scale}) begin
            hi_c = full_scale;
        end else begin
            hi_c = in_data.raw_high[DATA_W-1:0];
        end

        shown_low_next  = shown_low_reg;
        shown_high_next = shown_high_reg;
        if (accept && in_data.present) begin
            shown_low_next  = lo_c;
            shown_high_next = hi_c;
        end

        data_next.index      = in_data.index;
        data_next.present    = in_data.present;
        data_next.value      = in_data.value;
        data_next.ended      = in_data.ended;
        data_next.range_low  = in_data.present ? lo_c : shown_low_reg;
        data_next.range_high = in_data.present ? hi_c : shown_high_reg;
        data_next.changed    = in_data.present &&
                               (lo_c != shown_low_reg || hi_c != shown_high_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            shown_low_reg  <= '0;
            shown_high_reg <= SHOWN_HIGH_RESET;
        end else begin
            shown_low_reg  <= shown_low_next;
            shown_high_reg <= shown_high_next;
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= data_next;
        end
    end

endmodule
